### src/bub_pkg.sv
// bub_pkg: shared constants for the bezier undersample bitcrusher
// no dependencies; used by bub_mul and bezier_undersample_bitcrush_core
`timescale 1ns / 1ps

package bub_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int MUL_B_WIDTH      = 26;

  localparam int REZ_W   = 17;
  localparam int TRIM_W  = 17;
  localparam int QGAIN_W = 25;
  localparam int QINV_W  = 24;
  localparam int QOFF_W  = 23;
  localparam int WET_W   = 18;
  localparam int DRY_W   = 17;
  localparam int CFG_W   = 25;
  localparam int PHASE_W = 18;
  localparam int POS_W   = 19;
  localparam int OM_W    = 21;

  localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;
  localparam logic [PHASE_W-1:0] PHASE_ONE   = 18'd65536;

  localparam logic [2:0] REG_REZ     = 3'd0;
  localparam logic [2:0] REG_TRIM    = 3'd1;
  localparam logic [2:0] REG_STEPPED = 3'd2;
  localparam logic [2:0] REG_QGAIN   = 3'd3;
  localparam logic [2:0] REG_QINV    = 3'd4;
  localparam logic [2:0] REG_QOFF    = 3'd5;
  localparam logic [2:0] REG_WET     = 3'd6;
  localparam logic [2:0] REG_DRY     = 3'd7;

  localparam logic [REZ_W-1:0]   REZ_RST   = 17'd8192;
  localparam logic [TRIM_W-1:0]  TRIM_RST  = 17'd58000;
  localparam logic [QGAIN_W-1:0] QGAIN_RST = 25'd65536;
  localparam logic [QINV_W-1:0]  QINV_RST  = 24'd65536;
  localparam logic signed [WET_W-1:0] WET_ONE = 18'sd65536;
  localparam logic [DRY_W-1:0]   DRY_ONE   = 17'd65536;

endpackage

### src/bub_mul.sv
// bub_mul: bit-serial signed shift-add multiplier, one multiplier bit per cycle
// depends on bub_pkg
`timescale 1ns / 1ps

module bub_mul
  import bub_pkg::*;
#(
  parameter int A_WIDTH = SAMPLE_WIDTH_DEF + 8,
  parameter int B_WIDTH = MUL_B_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [A_WIDTH-1:0]         a,
  input  logic signed [B_WIDTH-1:0]         b,
  output logic                              done,
  output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

  localparam int PW = A_WIDTH + B_WIDTH;
  localparam int CW = $clog2(B_WIDTH);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic signed [PW-1:0] a_sh;
  logic [B_WIDTH-1:0]   b_sh;
  logic signed [PW-1:0] addend;

  assign addend = b_sh[0] ? a_sh : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= PW'(a);
        b_sh <= b;
        p    <= '0;
      end else if (busy) begin
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(B_WIDTH - 1)) begin
          // top bit carries negative weight
          p    <= p - addend;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          p <= p + addend;
        end
      end
    end
  end

endmodule

### src/bezier_undersample_bitcrush_core.sv
// bezier_undersample_bitcrush_core: undersampling bitcrusher with bezier reconstruction
// depends on bub_pkg and bub_mul
`timescale 1ns / 1ps

// One sample in, one sample out. All products go through one bit-serial multiplier
// that resolves one multiplier bit per cycle.
// A sample needs ten products, twelve when the phase wraps, and after the last product
// the result is loaded into the output register.
// A finished sample waits in the output register while the next one is taken.
// Configuration writes are always ready and are meant to happen while idle.

module bezier_undersample_bitcrush_core
  import bub_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int SW  = W + 8;
  localparam int PTW = W + 4;
  localparam int AW  = W + 8;
  localparam int BW  = MUL_B_WIDTH;
  localparam int PW  = AW + BW;
  localparam int TW  = PW + 2;
  localparam int QSR = (W <= 25) ? 25 - W : 0;
  localparam int QSL = (W > 25) ? W - 25 : 0;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_QG   = 4'd2;
  localparam logic [3:0] S_QI   = 4'd3;
  localparam logic [3:0] S_POS  = 4'd4;
  localparam logic [3:0] S_C0   = 4'd5;
  localparam logic [3:0] S_C1   = 4'd6;
  localparam logic [3:0] S_C2   = 4'd7;
  localparam logic [3:0] S_C3   = 4'd8;
  localparam logic [3:0] S_C4   = 4'd9;
  localparam logic [3:0] S_C5   = 4'd10;
  localparam logic [3:0] S_WET  = 4'd11;
  localparam logic [3:0] S_DRY  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] st;

  logic [REZ_W-1:0]        rez_step;
  logic [TRIM_W-1:0]       freq_trim;
  logic                    stepped_mode;
  logic [QGAIN_W-1:0]      quant_gain;
  logic [QINV_W-1:0]       quant_inv_gain;
  logic [QOFF_W-1:0]       quant_offset;
  logic signed [WET_W-1:0] wet_gain;
  logic [DRY_W-1:0]        dry_gain;

  logic [PHASE_W-1:0]     phase_acc;
  logic signed [SW-1:0]   sum_acc;
  logic signed [SW-1:0]   prev_sum;
  logic signed [PTW-1:0]  point_newest;
  logic signed [PTW-1:0]  point_middle;
  logic signed [PTW-1:0]  point_oldest;
  logic signed [PTW-1:0]  prev_curve;

  logic signed [W-1:0]    x;
  logic signed [OM_W-1:0] pos;
  logic signed [OM_W-1:0] om;
  logic signed [AW-1:0]   cb;
  logic signed [AW-1:0]   ba;
  logic signed [TW-1:0]   t;

  logic                   mul_start;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic                   mul_done;
  logic signed [PW-1:0]   mul_p;

  logic [PHASE_W:0]       phase_add;
  logic signed [TW-1:0]   sum_w;
  logic signed [SW-1:0]   sum_n;
  logic signed [TW-1:0]   avg_w;
  logic signed [TW-1:0]   scaled_w;
  logic signed [TW-1:0]   pair_w;
  logic signed [TW-1:0]   pair_sh;
  logic signed [TW-1:0]   quant_w;
  logic signed [TW-1:0]   curve_w;
  logic signed [PTW-1:0]  curve_n;
  logic signed [PTW:0]    res_n;
  logic signed [TW-1:0]   out_w;
  logic [POS_W-1:0]       pos_n;
  logic signed [WET_W-1:0] wet_c;
  logic [DRY_W-1:0]       dry_c;

  function automatic logic signed [TW-1:0] sat(input logic signed [TW-1:0] v, input int bits);
    logic signed [TW-1:0] lim;
    lim = TW'(1) <<< (bits - 1);
    if (v >= lim) begin
      return lim - TW'(1);
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  bub_mul #(
    .A_WIDTH(AW),
    .B_WIDTH(BW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  assign in_stall  = (st != S_IDLE);
  assign cfg_ready = 1'b1;
  assign phase_add = {1'b0, phase_acc} + (PHASE_W + 1)'(rez_step);

  always_comb begin
    sum_w    = sat(TW'(sum_acc) + (TW'(mul_p) >>> 16), SW);
    sum_n    = sum_w[SW-1:0];
    avg_w    = sat((TW'(sum_n) + TW'(prev_sum)) >>> 1, PTW);
    scaled_w = (TW'(mul_p) <<< 1) + (TW'($signed({1'b0, quant_offset})) <<< (W - 16));
    pair_w   = t + TW'(mul_p);
    pair_sh  = pair_w >>> 16;
    quant_w  = sat((TW'(mul_p) >>> QSR) <<< QSL, PTW);
    curve_w  = sat((TW'(point_middle) + pair_sh) >>> 3, PTW);
    curve_n  = curve_w[PTW-1:0];
    res_n    = (PTW + 1)'(curve_n) + (PTW + 1)'(prev_curve);
    out_w    = sat(t >>> 16, W);
    pos_n    = mul_p[16 +: POS_W];
    if (wet_gain > WET_ONE) begin
      wet_c = WET_ONE;
    end else if (wet_gain < -WET_ONE) begin
      wet_c = -WET_ONE;
    end else begin
      wet_c = wet_gain;
    end
    dry_c = (dry_gain > DRY_ONE) ? DRY_ONE : dry_gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rez_step       <= REZ_RST;
      freq_trim      <= TRIM_RST;
      stepped_mode   <= 1'b1;
      quant_gain     <= QGAIN_RST;
      quant_inv_gain <= QINV_RST;
      quant_offset   <= '0;
      wet_gain       <= WET_ONE;
      dry_gain       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REZ:     rez_step       <= cfg_data[REZ_W-1:0];
        REG_TRIM:    freq_trim      <= cfg_data[TRIM_W-1:0];
        REG_STEPPED: stepped_mode   <= cfg_data[0];
        REG_QGAIN:   quant_gain     <= cfg_data[QGAIN_W-1:0];
        REG_QINV:    quant_inv_gain <= cfg_data[QINV_W-1:0];
        REG_QOFF:    quant_offset   <= cfg_data[QOFF_W-1:0];
        REG_WET:     wet_gain       <= $signed(cfg_data[WET_W-1:0]);
        REG_DRY:     dry_gain       <= cfg_data[DRY_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      out_valid    <= 1'b0;
      mul_start    <= 1'b0;
      phase_acc    <= PHASE_ONE;
      sum_acc      <= '0;
      prev_sum     <= '0;
      point_newest <= '0;
      point_middle <= '0;
      point_oldest <= '0;
      prev_curve   <= '0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && !out_stall && st != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            x         <= in_sample;
            phase_acc <= phase_add[PHASE_W] ? PHASE_MAX : phase_add[PHASE_W-1:0];
            mul_a     <= AW'(in_sample);
            mul_b     <= $signed(BW'(rez_step));
            mul_start <= 1'b1;
            st        <= S_SUM;
          end
        end
        S_SUM: begin
          if (mul_done) begin
            if (phase_acc > PHASE_ONE) begin
              phase_acc    <= stepped_mode ? '0 : phase_acc - PHASE_ONE;
              prev_sum     <= sum_n;
              sum_acc      <= '0;
              point_oldest <= point_middle;
              point_middle <= point_newest;
              mul_a        <= AW'($signed(avg_w[PTW-1:0]));
              mul_b        <= $signed(BW'(quant_gain));
              st           <= S_QG;
            end else begin
              sum_acc <= sum_n;
              mul_a   <= $signed(AW'(phase_acc));
              mul_b   <= $signed(BW'(freq_trim));
              st      <= S_POS;
            end
            mul_start <= 1'b1;
          end
        end
        S_QG: begin
          if (mul_done) begin
            mul_a     <= AW'(scaled_w >>> (W + 8));
            mul_b     <= $signed(BW'(quant_inv_gain));
            mul_start <= 1'b1;
            st        <= S_QI;
          end
        end
        S_QI: begin
          if (mul_done) begin
            point_newest <= quant_w[PTW-1:0];
            mul_a        <= $signed(AW'(phase_acc));
            mul_b        <= $signed(BW'(freq_trim));
            mul_start    <= 1'b1;
            st           <= S_POS;
          end
        end
        S_POS: begin
          if (mul_done) begin
            pos       <= $signed(OM_W'(pos_n));
            om        <= $signed(OM_W'(PHASE_ONE)) - $signed(OM_W'(pos_n));
            mul_a     <= AW'(point_oldest);
            mul_b     <= BW'($signed(OM_W'(PHASE_ONE)) - $signed(OM_W'(pos_n)));
            mul_start <= 1'b1;
            st        <= S_C0;
          end
        end
        S_C0: begin
          if (mul_done) begin
            t         <= TW'(mul_p);
            mul_a     <= AW'(point_middle);
            mul_b     <= BW'(pos);
            mul_start <= 1'b1;
            st        <= S_C1;
          end
        end
        S_C1: begin
          if (mul_done) begin
            cb        <= pair_sh[AW-1:0];
            mul_a     <= AW'(point_middle);
            mul_b     <= BW'(om);
            mul_start <= 1'b1;
            st        <= S_C2;
          end
        end
        S_C2: begin
          if (mul_done) begin
            t         <= TW'(mul_p);
            mul_a     <= AW'(point_newest);
            mul_b     <= BW'(pos);
            mul_start <= 1'b1;
            st        <= S_C3;
          end
        end
        S_C3: begin
          if (mul_done) begin
            ba        <= pair_sh[AW-1:0];
            mul_a     <= cb;
            mul_b     <= BW'(om);
            mul_start <= 1'b1;
            st        <= S_C4;
          end
        end
        S_C4: begin
          if (mul_done) begin
            t         <= TW'(mul_p);
            mul_a     <= ba;
            mul_b     <= BW'(pos);
            mul_start <= 1'b1;
            st        <= S_C5;
          end
        end
        S_C5: begin
          if (mul_done) begin
            prev_curve <= curve_n;
            mul_a      <= AW'(res_n);
            mul_b      <= BW'(wet_c);
            mul_start  <= 1'b1;
            st         <= S_WET;
          end
        end
        S_WET: begin
          if (mul_done) begin
            t         <= TW'(mul_p);
            mul_a     <= AW'(x);
            mul_b     <= $signed(BW'(dry_c));
            mul_start <= 1'b1;
            st        <= S_DRY;
          end
        end
        S_DRY: begin
          if (mul_done) begin
            t  <= pair_w;
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_sample <= out_w[W-1:0];
            out_valid  <= 1'b1;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (st != S_IDLE && st != S_OUT))
    else $error("multiplier finished with no product pending");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (st == S_SUM && mul_start))
    else $error("accepted request did not start the sum product");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (st == S_QG) |-> (sum_acc == '0))
    else $error("sum not cleared after phase wrap");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(st) == S_OUT))
    else $error("output loaded outside the output step");

endmodule

### tb/tb_bezier_undersample_bitcrush_core.sv
// tb_bezier_undersample_bitcrush_core: self-checking bench for the bezier bitcrusher core
// depends on bub_pkg and bezier_undersample_bitcrush_core; predicts each output sample
`timescale 1ns / 1ps

module tb_bezier_undersample_bitcrush_core;
  import bub_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_REZ;
  logic [CFG_W-1:0] cfg_data = '0;

  bezier_undersample_bitcrush_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // register copy
  longint m_rez, m_trim, m_stepped, m_qgain, m_qinv, m_qoff, m_wet, m_dry;
  // crusher state copy
  longint s_phase, s_sum, s_psum, s_newest, s_middle, s_oldest, s_pcurve;

  logic signed [SW-1:0] expected_samples[$];
  int mismatches = 0;
  longint cycles = 0;
  int hold_cycles = 0;
  bit stall_on = 1'b1;

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint crush_point(longint avg);
    longint scaled;
    longint n;
    longint v;
    scaled = avg * m_qgain * 2 + (m_qoff <<< (SW - 16));
    n = scaled >>> (SW + 8);
    v = (n * m_qinv) >>> (25 - SW);
    return sat_to(v, SW + 4);
  endfunction

  function automatic logic signed [SW-1:0] crush_sample(logic signed [SW-1:0] s);
    longint x;
    longint pos;
    longint om;
    longint cb;
    longint ba;
    longint curve;
    longint res;
    longint avg;
    longint wet;
    longint dry;
    x = longint'(s);
    s_phase = s_phase + m_rez;
    if (s_phase > 262143) s_phase = 262143;
    s_sum = sat_to(s_sum + ((x * m_rez) >>> 16), SW + 8);
    if (s_phase > 65536) begin
      if (m_stepped != 0) s_phase = 0;
      else s_phase = s_phase - 65536;
      avg = sat_to((s_sum + s_psum) >>> 1, SW + 4);
      s_psum = s_sum;
      s_oldest = s_middle;
      s_middle = s_newest;
      s_newest = crush_point(avg);
      s_sum = 0;
    end
    pos = (s_phase * m_trim) >>> 16;
    om = 65536 - pos;
    cb = (s_oldest * om + s_middle * pos) >>> 16;
    ba = (s_middle * om + s_newest * pos) >>> 16;
    curve = s_middle + ((cb * om + ba * pos) >>> 16);
    curve = sat_to(curve >>> 3, SW + 4);
    res = curve + s_pcurve;
    s_pcurve = curve;
    wet = m_wet;
    if (wet > 65536) wet = 65536;
    if (wet < -65536) wet = -65536;
    dry = (m_dry > 65536) ? 65536 : m_dry;
    res = sat_to((wet * res + dry * x) >>> 16, SW);
    return SW'(res);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bezier_undersample_bitcrush_core: FAIL");
      $finish;
    end
  end

  // predictor on accepted requests
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) expected_samples.push_back(crush_sample(in_sample));
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output %0d", out_sample);
      end else begin
        if (out_sample !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d got %0d", expected_samples[0], out_sample);
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_on) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cfg_write(logic [2:0] idx, longint value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_REZ:     m_rez = value & 64'h1FFFF;
      REG_TRIM:    m_trim = value & 64'h1FFFF;
      REG_STEPPED: m_stepped = value & 1;
      REG_QGAIN:   m_qgain = value & 64'h1FFFFFF;
      REG_QINV:    m_qinv = value & 64'hFFFFFF;
      REG_QOFF:    m_qoff = value & 64'h7FFFFF;
      REG_WET:     m_wet = longint'($signed(18'(value)));
      default:     m_dry = value & 64'h1FFFF;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(logic signed [SW-1:0] s);
    @(negedge clk);
    in_valid = 1'b1;
    in_sample = s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drain();
    idle_gap(0);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic send_bursts(int count, bit wide);
    int left;
    int burst;
    logic signed [SW-1:0] s;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        case ($urandom_range(0, 9))
          0: s = {1'b0, {(SW-1){1'b1}}};
          1: s = {1'b1, {(SW-1){1'b0}}};
          2: s = SW'($urandom_range(0, 31)) - SW'(16);
          default: s = wide ? SW'($urandom) : SW'($signed(SW'($urandom)) >>> 4);
        endcase
        send_item(s);
        burst--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 20));
    end
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      0: cfg_write(REG_REZ, 33);
      1: cfg_write(REG_REZ, 65536);
      default: cfg_write(REG_REZ, $urandom_range(2000, 131071));
    endcase
    cfg_write(REG_TRIM, ($urandom_range(0, 4) == 0) ? 131071 : $urandom_range(0, 65536));
    cfg_write(REG_STEPPED, $urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: cfg_write(REG_QGAIN, 362);
      1: cfg_write(REG_QGAIN, $urandom_range(0, 33554431));
      default: cfg_write(REG_QGAIN, 256 << $urandom_range(0, 16));
    endcase
    cfg_write(REG_QINV, $urandom_range(0, 16777215));
    cfg_write(REG_QOFF, $urandom_range(0, 8388607));
    cfg_write(REG_WET, $urandom_range(0, 262143));
    cfg_write(REG_DRY, $urandom_range(0, 131071));
  endtask

  task automatic test_directed_extremes();
    send_item({1'b0, {(SW-1){1'b1}}});
    send_item({1'b1, {(SW-1){1'b0}}});
    send_item('0);
    send_item(SW'(-1));
    send_item(SW'(1));
    wait_drain();
    cfg_write(REG_REZ, 65536);
    cfg_write(REG_TRIM, 65536);
    cfg_write(REG_STEPPED, 0);
    cfg_write(REG_QGAIN, 362);
    cfg_write(REG_QINV, 11863283);
    cfg_write(REG_QOFF, 5931642);
    cfg_write(REG_WET, -65536);
    cfg_write(REG_DRY, 65536);
    repeat (4) send_item({1'b0, {(SW-1){1'b1}}});
    repeat (4) send_item({1'b1, {(SW-1){1'b0}}});
    wait_drain();
    // out-of-range gains get clamped, trim past one extrapolates
    cfg_write(REG_REZ, 33);
    cfg_write(REG_TRIM, 131071);
    cfg_write(REG_STEPPED, 1);
    cfg_write(REG_QGAIN, 16777216);
    cfg_write(REG_QINV, 256);
    cfg_write(REG_QOFF, 0);
    cfg_write(REG_WET, 131071);
    cfg_write(REG_DRY, 131071);
    repeat (3) send_item({1'b0, {(SW-1){1'b1}}});
    wait_drain();
    cfg_write(REG_WET, 131072);
    cfg_write(REG_REZ, 131071);
    repeat (3) send_item({1'b1, {(SW-1){1'b0}}});
    wait_drain();
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      random_config();
      send_bursts(125, $urandom_range(0, 3) != 0);
      wait_drain();
    end
  endtask

  task automatic test_no_idle();
    stall_on = 1'b0;
    cfg_write(REG_REZ, 40000);
    cfg_write(REG_STEPPED, 0);
    repeat (40) send_item(SW'($urandom));
    wait_drain();
    stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 3000;
    repeat (25) send_item(SW'($urandom));
    // sender pause until all results are back
    wait_drain();
  endtask

  initial begin
    m_rez = REZ_RST; m_trim = TRIM_RST; m_stepped = 1;
    m_qgain = QGAIN_RST; m_qinv = QINV_RST; m_qoff = 0;
    m_wet = 65536; m_dry = 0;
    s_phase = 65536; s_sum = 0; s_psum = 0;
    s_newest = 0; s_middle = 0; s_oldest = 0; s_pcurve = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_extremes();
    test_backpressure();
    test_random_settings();
    test_no_idle();
    test_backpressure();
    wait_drain();
    if (mismatches == 0) begin
      $display("tb_bezier_undersample_bitcrush_core: PASS");
    end else begin
      $display("tb_bezier_undersample_bitcrush_core: FAIL");
    end
    $finish;
  end

endmodule

### bezier_undersample_bitcrush_core.f
src/bub_pkg.sv
src/bub_mul.sv
src/bezier_undersample_bitcrush_core.sv
tb/tb_bezier_undersample_bitcrush_core.sv
